FILE: hw/rtl/clc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC record line checker package
// Shared constants, word types and helper functions for the line checker:
// the input and result words, the command passed from the front to the back,
// the CRC-32 byte update and the hex digit decoder.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Line framing.
    localparam int TRAILER_LEN = 10;
    localparam int MAX_PREFIX  = 8;
    localparam int PREFIX_W    = 64;
    localparam int PLEN_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int FILL_W      = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [7:0]         CHAR_TAB  = 8'h09;
    localparam logic [7:0]         CHAR_NL   = 8'h0A;

    // Reflected CRC-32.
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Queue depths.
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Verdict codes.
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BAD_FORMAT   = 2'd1;
    localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd2;

    // Result kinds.
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Configuration register indexes.
    localparam int              CFG_INDEX_W       = 2;
    localparam logic [1:0]      CFG_PREFIX_BYTES  = 2'd0;
    localparam logic [1:0]      CFG_PREFIX_LENGTH = 2'd1;

    // What the back has to do with one byte.
    typedef enum logic [1:0] {
        ACT_PREFIX,
        ACT_FILL,
        ACT_SHIFT
    } act_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  body_byte;
        logic [1:0]  status;
        logic [31:0] trailer_crc;
        logic        run_last;
    } out_t;

    typedef struct packed {
        act_t              act;
        logic [FILL_W-1:0] fill_idx;
        logic [7:0]        data;
        logic              line_end;
        logic              form_ok;
    } cmd_t;

    // One byte through the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // Hex digit decode: bit 4 is the valid flag, bits 3..0 the value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/clc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line checker front end
// Holds the configuration registers and the per-line byte count. Each
// accepted byte is classified as a prefix byte, a window fill or a window
// shift, and the prefix is checked here.
// ----------------------------------------------------------------------------
module clc_front
    import clc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  in_t                    item,
    input  logic                   accept,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PREFIX_W-1:0]    cfg_data,
    output cmd_t                   cmd
);

    logic [PREFIX_W-1:0] prefix_bytes_reg;
    logic [PLEN_W-1:0]   prefix_length_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                good_reg;
    logic                good_next;

    logic [PLEN_W-1:0]   plen;
    logic                in_prefix;
    logic [7:0]          want;
    logic [COUNT_W-1:0]  diff;
    logic                shift;
    logic [COUNT_W-1:0]  count_inc;
    logic                full_end;
    logic                good_now;

    // Effective prefix length, capped at the largest prefix.
    assign plen = (prefix_length_reg > PLEN_W'(MAX_PREFIX)) ? PLEN_W'(MAX_PREFIX)
                                                            : prefix_length_reg;

    // Prefix check for bytes that fall inside the prefix.
    assign in_prefix = count_reg < COUNT_W'(plen);
    assign want      = prefix_bytes_reg[{count_reg[2:0], 3'b000} +: 8];
    assign good_now  = good_reg && !(in_prefix && (want != item.line_byte));

    // Window fill position derived from the byte count.
    assign diff  = (count_reg <= COUNT_W'(plen)) ? '0 : (count_reg - COUNT_W'(plen));
    assign shift = diff >= COUNT_W'(TRAILER_LEN);

    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : (count_reg + 1'b1);
    assign full_end  = {1'b0, count_inc} >= ({2'b00, plen} + 6'(TRAILER_LEN));

    // Command for the back end.
    always_comb
    begin
        cmd.data     = item.line_byte;
        cmd.line_end = item.line_end;
        cmd.form_ok  = good_now && full_end;
        cmd.fill_idx = diff[FILL_W-1:0];
        if (in_prefix)
        begin
            cmd.act = ACT_PREFIX;
        end
        else if (shift)
        begin
            cmd.act = ACT_SHIFT;
        end
        else
        begin
            cmd.act = ACT_FILL;
        end
    end

    // Line state; a line end starts the next line afresh.
    always_comb
    begin
        count_next = count_reg;
        good_next  = good_reg;
        if (accept)
        begin
            if (item.line_end)
            begin
                count_next = '0;
                good_next  = 1'b1;
            end
            else
            begin
                count_next = count_inc;
                good_next  = good_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            good_reg  <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            good_reg  <= good_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bytes_reg  <= '0;
            prefix_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PREFIX_BYTES:  prefix_bytes_reg  <= cfg_data;
                CFG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[PLEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // A line end always leaves the counter cleared.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.line_end |=> count_reg == '0 && good_reg)
        else $error("line end did not clear the line state");

endmodule

FILE: hw/rtl/clc_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line checker command queue
// A short queue of classified bytes between the front and the back end, so
// that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module clc_cmd_queue
    import clc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             q_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full     = cnt_reg == CNT_W'(CMD_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_cmd   = q_reg[rd_ptr_reg];

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/clc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line checker back end
// Runs the trailer window and the CRC over body bytes, builds the end of
// line verdict and holds finished results in a two-entry output queue.
// ----------------------------------------------------------------------------
module clc_back
    import clc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic empty,
    input  logic pop,
    output out_t result
);

    localparam int RPTR_W = $clog2(RES_DEPTH);
    localparam int RCNT_W = $clog2(RES_DEPTH + 1);

    logic [31:0]       crc_reg;
    logic [31:0]       crc_next;
    logic [7:0]        win_reg [TRAILER_LEN];
    logic [7:0]        win_next [TRAILER_LEN];
    logic              pend_reg;
    logic              pend_next;
    logic              pend_ok_reg;
    logic              pend_ok_next;

    out_t              res_q_reg [RES_DEPTH];
    logic [RPTR_W-1:0] res_wr_reg;
    logic [RPTR_W-1:0] res_rd_reg;
    logic [RCNT_W-1:0] res_cnt_reg;
    logic              res_space;
    logic              res_push;
    logic              res_pop;
    out_t              res_new;

    logic [4:0]        digit [8];
    logic              digits_ok;
    logic [31:0]       stored;
    logic              form_ok;
    out_t              verdict;

    assign res_space = res_cnt_reg < RCNT_W'(RES_DEPTH);
    assign res_pop   = pop && !empty;
    assign empty     = res_cnt_reg == '0;
    assign result    = res_q_reg[res_rd_reg];

    // Trailer decode: tab, eight hex digits, newline.
    always_comb
    begin
        digits_ok = 1'b1;
        stored    = '0;
        for (int i = 0; i < 8; i++)
        begin
            digit[i]  = hex_digit(win_reg[i + 1]);
            digits_ok = digits_ok && digit[i][4];
            stored    = {stored[27:0], digit[i][3:0]};
        end
    end

    assign form_ok = pend_ok_reg && digits_ok && (win_reg[0] == CHAR_TAB)
                     && (win_reg[TRAILER_LEN - 1] == CHAR_NL);

    always_comb
    begin
        verdict.result_kind = KIND_VERDICT;
        verdict.body_byte   = '0;
        verdict.run_last    = 1'b1;
        if (!form_ok)
        begin
            verdict.status      = STATUS_BAD_FORMAT;
            verdict.trailer_crc = '0;
        end
        else
        begin
            verdict.status      = (~crc_reg == stored) ? STATUS_OK : STATUS_CRC_MISMATCH;
            verdict.trailer_crc = stored;
        end
    end

    // Command execution: at most one result a cycle; a line end leaves a
    // verdict pending, which goes out once the output queue has room.
    always_comb
    begin
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_new      = verdict;
        crc_next     = crc_reg;
        win_next     = win_reg;
        pend_next    = pend_reg;
        pend_ok_next = pend_ok_reg;
        if (pend_reg)
        begin
            if (res_space)
            begin
                res_push  = 1'b1;
                pend_next = 1'b0;
                crc_next  = CRC_INIT;
                for (int i = 0; i < TRAILER_LEN; i++)
                begin
                    win_next[i] = '0;
                end
            end
        end
        else if (cmd_valid)
        begin
            unique case (cmd.act)
                ACT_SHIFT:
                begin
                    if (res_space)
                    begin
                        cmd_pop             = 1'b1;
                        res_push            = 1'b1;
                        res_new.result_kind = KIND_BODY;
                        res_new.body_byte   = win_reg[0];
                        res_new.status      = STATUS_OK;
                        res_new.trailer_crc = '0;
                        res_new.run_last    = !cmd.line_end;
                        crc_next            = crc_byte(crc_reg, win_reg[0]);
                        for (int i = 0; i < TRAILER_LEN - 1; i++)
                        begin
                            win_next[i] = win_reg[i + 1];
                        end
                        win_next[TRAILER_LEN - 1] = cmd.data;
                    end
                end
                ACT_FILL:
                begin
                    cmd_pop               = 1'b1;
                    win_next[cmd.fill_idx] = cmd.data;
                end
                ACT_PREFIX:
                begin
                    cmd_pop = 1'b1;
                end
                default:
                begin
                    cmd_pop = 1'b1;
                end
            endcase
            if (cmd_pop && cmd.line_end)
            begin
                pend_next    = 1'b1;
                pend_ok_next = cmd.form_ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            pend_reg    <= 1'b0;
            pend_ok_reg <= 1'b0;
            for (int i = 0; i < TRAILER_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            crc_reg     <= crc_next;
            pend_reg    <= pend_next;
            pend_ok_reg <= pend_ok_next;
            win_reg     <= win_next;
        end
    end

    // Output queue storage.
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_q_reg[res_wr_reg] <= res_new;
        end
    end

    // Output queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_reg <= res_wr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_reg <= res_rd_reg + 1'b1;
            end
            if (res_push && !res_pop)
            begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
            end
            else if (res_pop && !res_push)
            begin
                res_cnt_reg <= res_cnt_reg - 1'b1;
            end
        end
    end

    // No new command is taken while a verdict is still owed.
    a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !cmd_pop)
        else $error("command taken while a verdict was pending");

    // A pending verdict goes out as soon as there is room.
    a_verdict_issued: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && res_space |=> !pend_reg && !empty)
        else $error("pending verdict not issued");

    // After a verdict the CRC starts again from its initial value.
    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_new.result_kind == KIND_VERDICT |=> crc_reg == CRC_INIT)
        else $error("CRC not restarted after a verdict");

endmodule

FILE: hw/rtl/crc_record_line_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC record line checker
// Checks framed record lines: prefix, body, then a tab, eight hex CRC-32
// digits and a newline. Body bytes are passed out and a verdict ends a line.
//
// Input words (line_byte, line_end) are pushed with push while full is low.
// Result words are read from result while empty is low and taken with pop.
// A body byte word leaves once the ten-byte trailer window is full; the word
// marked line_end also gives a verdict word carrying the status and the CRC
// read from the trailer.
// Configuration: cfg_index 0 writes the 64-bit prefix, index 1 the prefix
// length; cfg_ready is always high and writes belong between lines or while
// the block is idle.
// A body byte word passes through the command queue and then the output
// queue; a verdict word is first held as pending in the back end.
// Throughput: one byte per cycle while full is low; a pending verdict
// holds the back end after a line end, which the four-entry command queue
// absorbs unless line ends follow each other closely, as in runs of very short lines.
// When the reader stalls the two-entry output queue and then the command
// queue fill, and full rises. Reset clears the line state, the window, the
// CRC, both queues and the configuration registers.
// ----------------------------------------------------------------------------
module crc_record_line_checker_core
    import clc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  in_t                    item,
    output logic                   empty,
    input  logic                   pop,
    output out_t                   result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PREFIX_W-1:0]    cfg_data
);

    logic accept;
    cmd_t front_cmd;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    clc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .accept    (accept),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (front_cmd)
    );

    clc_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    clc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line checker testbench
// Sends framed record lines (prefix, body, tab, eight hex digits, newline)
// one byte word at a time and checks every body byte and verdict word
// against a model of the line state held in the bench. Well-formed
// lines dominate. Bad CRCs, prefix faults, damaged and lenient trailers,
// short lines and raw noise are mixed in. Both sides stall at random, and
// the prefix registers are rewritten between phases, at least once mid-line.
// ----------------------------------------------------------------------------
module tb;
    import clc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 1400;
    localparam int DRAIN_QUIET = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int PRINT_LIMIT = 40;

    // Indexes with no register behind them.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

    typedef enum {OP_BYTE, OP_REG, OP_DRAIN} op_kind_t;

    typedef enum {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_PREFIX,
        FLAW_TRAILER,
        FLAW_LENIENT,
        FLAW_SHORT
    } line_flaw_t;

    typedef struct {
        op_kind_t                kind;
        in_t                     word;
        logic [CFG_INDEX_W-1:0]  index;
        logic [PREFIX_W-1:0]     data;
    } pending_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    in_t                    item = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    out_t                   result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PREFIX_W-1:0]    cfg_data = '0;

    crc_record_line_checker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and expectation stores.
    pending_op_t pending_ops[$];
    out_t        expected_words[$];

    // Line state as the block should hold it.
    logic [PREFIX_W-1:0] prefix_reg;
    logic [PLEN_W-1:0]   prefix_len_reg;
    logic [31:0]         body_crc;
    logic [7:0]          window_bytes[TRAILER_LEN];
    logic [COUNT_W-1:0]  line_count;
    logic                prefix_match;

    // Configuration as seen by the line generator.
    logic [PREFIX_W-1:0] gen_prefix = '0;
    logic [PLEN_W-1:0]   gen_plen = '0;

    int  gen_bytes = 0;
    int  bytes_sent = 0;
    int  regs_written = 0;
    int  words_checked = 0;
    int  lines_ok = 0;
    int  lines_bad_format = 0;
    int  lines_crc_bad = 0;
    int  drains_done = 0;
    int  err_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  take_wait = 0;
    int  quiet = 0;
    bit  send_burst = 1'b0;
    bit  take_burst = 1'b0;
    logic stim_done = 1'b0;

    // Reflected CRC-32, one data bit at a time.
    function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ b[k])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n - 4'd10);
    endfunction

    // Byte k of a well-formed trailer carrying the given CRC.
    function automatic logic [7:0] trailer_byte(input logic [31:0] sum, input int k);
        if (k == 0)
            return CHAR_TAB;
        if (k == TRAILER_LEN - 1)
            return CHAR_NL;
        return hex_char(sum[4 * (8 - k) +: 4], bit'($urandom_range(0, 1)));
    endfunction

    function automatic int clamp_plen(input logic [PLEN_W-1:0] raw);
        return (raw > MAX_PREFIX) ? MAX_PREFIX : int'(raw);
    endfunction

    function automatic int window_fill();
        int pl;
        int f;
        pl = clamp_plen(prefix_len_reg);
        if (int'(line_count) <= pl)
            return 0;
        f = int'(line_count) - pl;
        return (f > TRAILER_LEN) ? TRAILER_LEN : f;
    endfunction

    task automatic clear_line_state();
        body_crc = CRC_INIT;
        for (int i = 0; i < TRAILER_LEN; i++)
            window_bytes[i] = 8'h00;
        line_count = '0;
        prefix_match = 1'b1;
    endtask

    task automatic apply_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [PREFIX_W-1:0] data);
        if (idx == CFG_PREFIX_BYTES)
            prefix_reg = data;
        else if (idx == CFG_PREFIX_LENGTH)
            prefix_len_reg = data[PLEN_W-1:0];
        regs_written++;
    endtask

    // Works out the words that one accepted line byte gives.
    task automatic predict_line_byte(input in_t w);
        int          pl;
        int          fill;
        int          v;
        logic [7:0]  old;
        logic        form_ok;
        logic [31:0] stored;
        out_t        r;
        pl = clamp_plen(prefix_len_reg);
        if (int'(line_count) < pl)
        begin
            if (prefix_reg[8 * line_count +: 8] != w.line_byte)
                prefix_match = 1'b0;
        end
        else
        begin
            fill = window_fill();
            if (fill >= TRAILER_LEN)
            begin
                old = window_bytes[0];
                body_crc = crc_next(body_crc, old);
                for (int i = 0; i < TRAILER_LEN - 1; i++)
                    window_bytes[i] = window_bytes[i + 1];
                window_bytes[TRAILER_LEN - 1] = w.line_byte;
                r = '0;
                r.result_kind = KIND_BODY;
                r.body_byte = old;
                r.run_last = !w.line_end;
                expected_words.push_back(r);
            end
            else
            begin
                window_bytes[fill] = w.line_byte;
            end
        end
        if (line_count < COUNT_MAX)
            line_count = line_count + 1'b1;

        if (w.line_end)
        begin
            form_ok = prefix_match && (window_fill() >= TRAILER_LEN) &&
                      window_bytes[0] == CHAR_TAB &&
                      window_bytes[TRAILER_LEN - 1] == CHAR_NL;
            stored = '0;
            for (int i = 1; i <= 8; i++)
            begin
                v = hex_value(window_bytes[i]);
                if (v < 0)
                    form_ok = 1'b0;
                else
                    stored = {stored[27:0], 4'(v)};
            end
            r = '0;
            r.result_kind = KIND_VERDICT;
            r.run_last = 1'b1;
            if (!form_ok)
            begin
                r.status = STATUS_BAD_FORMAT;
            end
            else
            begin
                r.trailer_crc = stored;
                r.status = (~body_crc == stored) ? STATUS_OK : STATUS_CRC_MISMATCH;
            end
            expected_words.push_back(r);
            clear_line_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (err_count < PRINT_LIMIT)
            $display("%0t mismatch, %s: expected %0h, got %0h", $realtime, what, want, got);
        err_count++;
    endtask

    task automatic check_result_word(input out_t got);
        out_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("word with nothing expected", '0, 64'(got));
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (got.result_kind != want.result_kind)
            report_mismatch("result_kind", 64'(want.result_kind), 64'(got.result_kind));
        if (got.body_byte != want.body_byte)
            report_mismatch("body_byte", 64'(want.body_byte), 64'(got.body_byte));
        if (got.status != want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.trailer_crc != want.trailer_crc)
            report_mismatch("trailer_crc", 64'(want.trailer_crc), 64'(got.trailer_crc));
        if (got.run_last != want.run_last)
            report_mismatch("run_last", 64'(want.run_last), 64'(got.run_last));
        if (want.result_kind == KIND_VERDICT)
        begin
            if (want.status == STATUS_OK)
                lines_ok++;
            else if (want.status == STATUS_BAD_FORMAT)
                lines_bad_format++;
            else
                lines_crc_bad++;
        end
    endtask

    // Stimulus building.
    task automatic add_byte(input logic [7:0] b, input logic last);
        pending_op_t op;
        op.kind = OP_BYTE;
        op.word.line_byte = b;
        op.word.line_end = last;
        op.index = '0;
        op.data = '0;
        pending_ops.push_back(op);
        gen_bytes++;
    endtask

    // A register write always waits for the block to go quiet first.
    task automatic add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PREFIX_W-1:0] data);
        pending_op_t op;
        op.kind = OP_DRAIN;
        op.word = '0;
        op.index = '0;
        op.data = '0;
        pending_ops.push_back(op);
        op.kind = OP_REG;
        op.index = idx;
        op.data = data;
        pending_ops.push_back(op);
        if (idx == CFG_PREFIX_BYTES)
            gen_prefix = data;
        else if (idx == CFG_PREFIX_LENGTH)
            gen_plen = data[PLEN_W-1:0];
    endtask

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (hex_value(b) >= 0 || b == CHAR_TAB || b == CHAR_NL)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // One line under the current prefix, optionally damaged.
    task automatic add_line(input int body_len, input line_flaw_t flaw);
        logic [7:0]  line_q[$];
        logic [31:0] acc;
        logic [31:0] sum;
        logic [7:0]  b;
        int          pl;
        int          pos;
        int          tpos;
        int          cut;
        pl = clamp_plen(gen_plen);
        for (int i = 0; i < pl; i++)
            line_q.push_back(gen_prefix[8 * i +: 8]);
        acc = CRC_INIT;
        for (int i = 0; i < body_len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            line_q.push_back(b);
            acc = crc_next(acc, b);
        end
        sum = ~acc;
        if (flaw == FLAW_CRC)
            sum = sum ^ (32'd1 << $urandom_range(0, 31));
        tpos = line_q.size();
        for (int k = 0; k < TRAILER_LEN; k++)
            line_q.push_back(trailer_byte(sum, k));

        case (flaw)
            FLAW_PREFIX:
            begin
                if (pl > 0)
                begin
                    pos = $urandom_range(0, pl - 1);
                    line_q[pos] = line_q[pos] ^ (8'd1 << $urandom_range(0, 7));
                end
            end
            FLAW_TRAILER:
            begin
                pos = tpos + $urandom_range(0, TRAILER_LEN - 1);
                line_q[pos] = non_hex_char();
            end
            FLAW_LENIENT:
            begin
                // The forms a lax parser would take: a space, a 0x mark,
                // a sign, or one digit too few.
                case ($urandom_range(0, 3))
                    0: line_q[tpos + 1] = 8'h20;
                    1:
                    begin
                        line_q[tpos + 1] = 8'h30;
                        line_q[tpos + 2] = ($urandom_range(0, 1) != 0) ? 8'h78 : 8'h58;
                    end
                    2: line_q[tpos + 1] = ($urandom_range(0, 1) != 0) ? 8'h2B : 8'h2D;
                    default: line_q.delete(tpos + 1);
                endcase
            end
            FLAW_SHORT:
            begin
                cut = $urandom_range(1, pl + TRAILER_LEN - 1);
                while (line_q.size() > cut)
                    b = line_q.pop_back();
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < line_q.size(); i++)
            add_byte(line_q[i], i == line_q.size() - 1);
    endtask

    task automatic add_phase_config();
        logic [PREFIX_W-1:0] data;
        case ($urandom_range(0, 3))
            0: data = '0;
            1: data = '1;
            default: data = {$urandom, $urandom};
        endcase
        add_reg(CFG_PREFIX_BYTES, data);
        data = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: data[PLEN_W-1:0] = 4'd0;
            1: data[PLEN_W-1:0] = 4'd8;
            2: data[PLEN_W-1:0] = 4'd15;
            default: data[PLEN_W-1:0] = 4'($urandom_range(0, 15));
        endcase
        add_reg(CFG_PREFIX_LENGTH, data);
        if ($urandom_range(0, 3) == 0)
            add_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                    {$urandom, $urandom});
    endtask

    // Driver: presents byte words and register writes from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic        nxt_push;
        logic        nxt_cfg;
        pending_op_t op;
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            send_gap = 0;
            quiet = 0;
        end
        else
        begin
            nxt_push = push;
            nxt_cfg = cfg_valid;
            if (push && !full)
            begin
                predict_line_byte(item);
                bytes_sent++;
                nxt_push = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 9);
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_register_write(cfg_index, cfg_data);
                nxt_cfg = 1'b0;
            end
            if (!nxt_push && !nxt_cfg)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_ops.size() > 0)
                begin
                    case (pending_ops[0].kind)
                        OP_BYTE:
                        begin
                            op = pending_ops.pop_front();
                            item <= op.word;
                            nxt_push = 1'b1;
                        end
                        OP_REG:
                        begin
                            op = pending_ops.pop_front();
                            cfg_index <= op.index;
                            cfg_data <= op.data;
                            nxt_cfg = 1'b1;
                        end
                        default:
                        begin
                            // Hold off until every word is out and the
                            // pipeline has had time to settle.
                            if (expected_words.size() == 0)
                            begin
                                quiet++;
                                if (quiet >= DRAIN_QUIET)
                                begin
                                    quiet = 0;
                                    op = pending_ops.pop_front();
                                    drains_done++;
                                end
                            end
                            else
                            begin
                                quiet = 0;
                            end
                        end
                    endcase
                end
                else
                begin
                    stim_done <= 1'b1;
                end
            end
            push <= nxt_push;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: takes result words with random stalls and checks each one.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic nxt_pop;
        if (!rst_n)
        begin
            pop <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            nxt_pop = pop;
            if (pop && !empty)
            begin
                check_result_word(result);
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                take_wait = take_burst ? 0 : $urandom_range(0, 9);
                nxt_pop = (take_wait == 0);
            end
            else if (!pop)
            begin
                if (take_wait <= 1)
                    nxt_pop = 1'b1;
                if (take_wait > 0)
                    take_wait--;
            end
            pop <= nxt_pop;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin : sequencer
        logic [31:0] acc;
        int          next_phase;
        int          pick;
        int          body_len;
        clear_line_state();
        prefix_reg = '0;
        prefix_len_reg = '0;

        // Directed: reset configuration, extreme body bytes, good trailer.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        acc = crc_next(crc_next(CRC_INIT, 8'h00), 8'hFF);
        for (int k = 0; k < TRAILER_LEN; k++)
            add_byte(trailer_byte(~acc, k), k == TRAILER_LEN - 1);
        // A line of a single byte is too short.
        add_byte(8'hFF, 1'b1);

        // Unused indexes, a full prefix and a length above the maximum.
        add_reg(CFG_UNUSED_2, '1);
        add_reg(CFG_UNUSED_3, '1);
        add_reg(CFG_PREFIX_BYTES, {$urandom, $urandom});
        add_reg(CFG_PREFIX_LENGTH, 64'd15);

        // Prefix length cut mid-line: the window refills from the new length
        // and two zero bytes become the body.
        for (int i = 0; i < 4; i++)
            add_byte(gen_prefix[8 * i +: 8], 1'b0);
        add_reg(CFG_PREFIX_LENGTH, 64'd2);
        acc = crc_next(crc_next(CRC_INIT, 8'h00), 8'h00);
        for (int k = 0; k < TRAILER_LEN; k++)
            add_byte(trailer_byte(~acc, k), k == TRAILER_LEN - 1);

        // A lenient trailer form is not accepted.
        add_line(0, FLAW_LENIENT);

        // A line that stops inside the prefix.
        add_reg(CFG_PREFIX_LENGTH, 64'd8);
        for (int i = 0; i < 3; i++)
            add_byte(gen_prefix[8 * i +: 8], i == 2);

        // Random phases, mostly well-formed lines.
        next_phase = gen_bytes;
        while (gen_bytes < ITEM_TARGET)
        begin
            if (gen_bytes >= next_phase)
            begin
                add_phase_config();
                next_phase = gen_bytes + $urandom_range(120, 200);
            end
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1: body_len = $urandom_range(13, 30);
                2: body_len = $urandom_range(31, 45);
                default: body_len = $urandom_range(0, 12);
            endcase
            if (pick < 55)
                add_line(body_len, FLAW_NONE);
            else if (pick < 70)
                add_line(body_len, FLAW_CRC);
            else if (pick < 77)
                add_line(body_len, FLAW_PREFIX);
            else if (pick < 85)
                add_line(body_len, FLAW_TRAILER);
            else if (pick < 91)
                add_line(body_len, FLAW_LENIENT);
            else if (pick < 96)
                add_line(body_len, FLAW_SHORT);
            else
            begin
                for (int i = $urandom_range(1, 15); i > 0; i--)
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_done);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d line bytes sent, %0d words checked, %0d register writes",
                 bytes_sent, words_checked, regs_written);
        $display("summary: verdicts %0d ok, %0d bad format, %0d crc mismatch, %0d drains",
                 lines_ok, lines_bad_format, lines_crc_bad, drains_done);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
